// ===== rtl/lcs_pkg.sv =====
// Package for the longest common subsequence block: types and constants.
`default_nettype none
package lcs_pkg;
  // Input transaction modes
  localparam logic [1:0] MODE_FIRST  = 2'd0;
  localparam logic [1:0] MODE_SECOND = 2'd1;
  localparam logic [1:0] MODE_RUN    = 2'd2;

  // Controller states, one-hot
  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_FRD     = 9'b000000010,
    ST_FILL    = 9'b000000100,
    ST_TRD     = 9'b000001000,
    ST_TCHK    = 9'b000010000,
    ST_TRUP    = 9'b000100000,
    ST_TDEC    = 9'b001000000,
    ST_EMRD    = 9'b010000000,
    ST_EMIT    = 9'b100000000
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/lcs_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module lcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/longest_common_subsequence.sv =====
// Top level of the longest common subsequence block.
// Load transactions (mode 0/1) leave busy low.
// A run fills each cell of the (n+1) x (m+1) table (top read, then write),
// then traces back (diagonal steps in ST_TRD; left/up steps in ST_TRD,
// ST_TCHK, ST_TRUP), setup in ST_EMRD, then one result per cycle (no stall).
// Synchronous active-low reset clears counts, flags and the controller only.
`default_nettype none
module longest_common_subsequence #(
  parameter int MAX_LEN = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_mode,
  input  wire logic [7:0] in_symbol,
  output logic            out_valid,
  output logic [7:0]      out_char,
  output logic            out_char_valid,
  output logic [5:0]      out_lcs_length,
  output logic            out_truncated,
  output logic            out_last
);
  localparam int SIDE = MAX_LEN + 1;
  localparam int TDEP = SIDE * SIDE;
  localparam int AW   = $clog2(TDEP);
  localparam int SW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW   = $clog2(MAX_LEN + 1);
  localparam int VW   = CW;

  lcs_pkg::state_t st_r;
  logic [CW-1:0] n1_r, n2_r, r_r, c_r, pos_r, len_r;
  logic          ovf_r;
  logic [VW-1:0] diag_r, left_r;

  // Text memories read asynchronously avoided: keep small texts in arrays of
  // registers read at one signal-chosen index each.
  logic [7:0] t1 [MAX_LEN];
  logic [7:0] t2 [MAX_LEN];
  logic [7:0] trc [MAX_LEN];

  logic          acc;
  assign acc  = start && !busy;
  assign busy = (st_r != lcs_pkg::ST_IDLE);

  // Score memory
  logic          s_we;
  logic [AW-1:0] s_wa, s_ra;
  logic [VW-1:0] s_wd, s_rd;
  lcs_ram #(.WIDTH(VW), .DEPTH(TDEP)) u_score (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

  function automatic logic [AW-1:0] addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    logic [AW+CW-1:0] p;
    p = (AW+CW)'(r) * (AW+CW)'(SIDE) + (AW+CW)'(c);
    return p[AW-1:0];
  endfunction

  logic [CW-1:0] r_dec, c_dec;
  assign r_dec = r_r - 1'b1;
  assign c_dec = c_r - 1'b1;

  logic [7:0] a_ch, b_ch;
  logic       match;
  assign a_ch  = (r_r == '0) ? 8'd0 : t1[SW'(r_dec)];
  assign b_ch  = (c_r == '0) ? 8'd0 : t2[SW'(c_dec)];
  assign match = (a_ch == b_ch);

  // Top neighbor of the current cell comes from memory (row 0 reads as zero)
  logic [VW-1:0] top_v;
  assign top_v = (r_r == '0) ? '0 : s_rd;

  logic [VW-1:0] fillv;
  always_comb begin
    if (r_r == '0 || c_r == '0) fillv = '0;
    else if (match) fillv = diag_r + 1'b1;
    else fillv = (left_r > top_v) ? left_r : top_v;
  end

  // Memory address/write control
  always_comb begin
    s_we = 1'b0;
    s_wa = addr(r_r, c_r);
    s_wd = fillv;
    s_ra = addr(r_r, c_r);
    case (st_r)
      lcs_pkg::ST_FRD:  s_ra = addr(r_dec, c_r);
      lcs_pkg::ST_FILL: s_we = 1'b1;
      lcs_pkg::ST_TRD:  s_ra = addr(r_r, c_dec);
      lcs_pkg::ST_TCHK: s_ra = addr(r_dec, c_r);
      default: ;
    endcase
  end

  logic tr_done;
  assign tr_done = (r_r == '0) || (c_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= lcs_pkg::ST_IDLE;
      n1_r <= '0; n2_r <= '0; ovf_r <= 1'b0;
      out_valid <= 1'b0;
      r_r <= '0; c_r <= '0; pos_r <= '0; len_r <= '0;
    end else begin
      out_valid <= 1'b0;
      case (st_r)
        lcs_pkg::ST_IDLE: begin
          if (acc) begin
            case (in_mode)
              lcs_pkg::MODE_FIRST:
                if (n1_r < CW'(MAX_LEN)) begin
                  t1[SW'(n1_r)] <= in_symbol; n1_r <= n1_r + 1'b1;
                end else ovf_r <= 1'b1;
              lcs_pkg::MODE_SECOND:
                if (n2_r < CW'(MAX_LEN)) begin
                  t2[SW'(n2_r)] <= in_symbol; n2_r <= n2_r + 1'b1;
                end else ovf_r <= 1'b1;
              lcs_pkg::MODE_RUN: begin
                st_r <= lcs_pkg::ST_FRD; r_r <= '0; c_r <= '0;
              end
              default: ;
            endcase
          end
        end
        // Fill: read top (row above) this cycle; left and diag are tracked
        lcs_pkg::ST_FRD: st_r <= lcs_pkg::ST_FILL;
        lcs_pkg::ST_FILL: begin
          // s_rd holds top of (r,c); update running neighbors
          if (c_r == n2_r) begin
            if (r_r == n1_r) begin
              len_r <= fillv; st_r <= lcs_pkg::ST_TRD; c_r <= n2_r;
              pos_r <= fillv;
            end else begin
              r_r <= r_r + 1'b1; c_r <= '0; left_r <= '0; diag_r <= '0;
              st_r <= lcs_pkg::ST_FRD;
            end
          end else begin
            c_r <= c_r + 1'b1; left_r <= fillv; diag_r <= top_v;
            st_r <= lcs_pkg::ST_FRD;
          end
        end
        // Traceback: read left, then top, then decide
        lcs_pkg::ST_TRD: begin
          if (tr_done) begin
            st_r <= lcs_pkg::ST_EMRD; r_r <= '0;
          end else if (match) begin
            if (pos_r != '0) begin
              trc[SW'(pos_r - 1'b1)] <= a_ch; pos_r <= pos_r - 1'b1;
            end
            r_r <= r_dec; c_r <= c_dec;
          end else st_r <= lcs_pkg::ST_TCHK;
        end
        lcs_pkg::ST_TCHK: begin left_r <= s_rd; st_r <= lcs_pkg::ST_TRUP; end
        lcs_pkg::ST_TRUP: begin
          if (left_r >= s_rd) c_r <= c_dec;
          else r_r <= r_dec;
          st_r <= lcs_pkg::ST_TRD;
        end
        lcs_pkg::ST_TDEC: st_r <= lcs_pkg::ST_TRD;
        // Emit, r_r counts results
        lcs_pkg::ST_EMRD: st_r <= lcs_pkg::ST_EMIT;
        lcs_pkg::ST_EMIT: begin
          out_valid      <= 1'b1;
          out_char       <= (len_r == '0) ? 8'd0 : trc[SW'(r_r)];
          out_char_valid <= (len_r != '0);
          out_lcs_length <= 6'(len_r);
          out_truncated  <= ovf_r;
          if (len_r == '0 || r_r + 1'b1 == len_r) begin
            out_last <= 1'b1; st_r <= lcs_pkg::ST_IDLE;
            n1_r <= '0; n2_r <= '0; ovf_r <= 1'b0;
          end else begin
            out_last <= 1'b0; r_r <= r_r + 1'b1;
          end
        end
        default: st_r <= lcs_pkg::ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy || $past(st_r == lcs_pkg::ST_EMIT)) else $error("result outside run");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy) else $error("last without return to idle");
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_valid == (out_lcs_length != 6'd0))) else $error("flag mismatch");
`endif
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the longest common subsequence block.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN = 32;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] symbol;
  } item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       ch_valid;
    logic [5:0] length;
    logic       trunc;
    logic       last;
  } lcs_out_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_mode;
  logic [7:0] in_symbol;
  logic       out_valid;
  logic [7:0] out_char;
  logic       out_char_valid;
  logic [5:0] out_lcs_length;
  logic       out_truncated;
  logic       out_last;

  longest_common_subsequence #(.MAX_LEN(MAX_LEN)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_symbol(in_symbol),
    .out_valid(out_valid), .out_char(out_char),
    .out_char_valid(out_char_valid), .out_lcs_length(out_lcs_length),
    .out_truncated(out_truncated), .out_last(out_last)
  );

  // Predictor state
  logic [7:0] str_a [MAX_LEN];
  logic [7:0] str_b [MAX_LEN];
  int         len_a, len_b;
  logic       dropped;

  item_t    pending_items[$];
  lcs_out_t expected_chars[$];
  int       errors, sent_count, run_count, got_count, idle_cycles;
  logic     calm;
  logic     stim_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // Compute the subsequence for the loaded strings, then clear them
  task automatic predict_lcs();
    logic [5:0] score [MAX_LEN+1][MAX_LEN+1];
    logic [7:0] seq [MAX_LEN];
    int r, c, pos, total;
    lcs_out_t e;
    for (r = 0; r <= len_a; r++)
      for (c = 0; c <= len_b; c++) begin
        if (r == 0 || c == 0) score[r][c] = '0;
        else if (str_a[r-1] == str_b[c-1]) score[r][c] = score[r-1][c-1] + 6'd1;
        else score[r][c] = (score[r][c-1] > score[r-1][c]) ? score[r][c-1] : score[r-1][c];
      end
    total = score[len_a][len_b];
    r = len_a; c = len_b; pos = total;
    while (r > 0 && c > 0) begin
      if (str_a[r-1] == str_b[c-1]) begin
        if (pos > 0) begin
          pos--;
          seq[pos] = str_a[r-1];
        end
        r--; c--;
      end else if (score[r][c-1] >= score[r-1][c]) c--;
      else r--;
    end
    if (total == 0) begin
      e = '{ch: 8'd0, ch_valid: 1'b0, length: 6'd0, trunc: dropped, last: 1'b1};
      expected_chars.push_back(e);
    end else begin
      for (int k = 0; k < total; k++) begin
        e = '{ch: seq[k], ch_valid: 1'b1, length: total[5:0], trunc: dropped,
              last: (k + 1 == total)};
        expected_chars.push_back(e);
      end
    end
    len_a = 0; len_b = 0; dropped = 1'b0;
  endtask

  task automatic apply_item(input item_t it);
    case (it.mode)
      lcs_pkg::MODE_FIRST:
        if (len_a < MAX_LEN) str_a[len_a++] = it.symbol; else dropped = 1'b1;
      lcs_pkg::MODE_SECOND:
        if (len_b < MAX_LEN) str_b[len_b++] = it.symbol; else dropped = 1'b1;
      lcs_pkg::MODE_RUN: begin
        run_count++;
        predict_lcs();
      end
      default: ;
    endcase
  endtask

  function automatic item_t mk(input logic [1:0] m, input logic [7:0] s);
    mk = '{mode: m, symbol: s};
  endfunction

  // Queue a string pair and a run; symbols drawn from an alphabet of alpha symbols
  task automatic queue_pair(input int na, input int nb, input int alpha);
    for (int i = 0; i < na; i++)
      pending_items.push_back(mk(lcs_pkg::MODE_FIRST,
                                 8'($urandom_range(0, alpha - 1)) ^ 8'h41));
    for (int i = 0; i < nb; i++)
      pending_items.push_back(mk(lcs_pkg::MODE_SECOND,
                                 8'($urandom_range(0, alpha - 1)) ^ 8'h41));
    pending_items.push_back(mk(lcs_pkg::MODE_RUN, 8'($urandom)));
  endtask

  // Stimulus
  initial begin
    int n;
    // empty run, extremes of the symbol, unused mode
    pending_items.push_back(mk(lcs_pkg::MODE_RUN, 8'hFF));
    pending_items.push_back(mk(lcs_pkg::MODE_FIRST, 8'h00));
    pending_items.push_back(mk(lcs_pkg::MODE_FIRST, 8'hFF));
    pending_items.push_back(mk(2'd3, 8'hAA));
    pending_items.push_back(mk(lcs_pkg::MODE_SECOND, 8'hFF));
    pending_items.push_back(mk(lcs_pkg::MODE_SECOND, 8'h00));
    pending_items.push_back(mk(lcs_pkg::MODE_RUN, 8'h00));
    // one string only: empty subsequence
    pending_items.push_back(mk(lcs_pkg::MODE_FIRST, 8'h55));
    pending_items.push_back(mk(lcs_pkg::MODE_RUN, 8'h00));
    // no common character
    pending_items.push_back(mk(lcs_pkg::MODE_FIRST, 8'h01));
    pending_items.push_back(mk(lcs_pkg::MODE_SECOND, 8'h02));
    pending_items.push_back(mk(lcs_pkg::MODE_RUN, 8'h00));
    // full strings with overflow on both sides
    for (int i = 0; i < MAX_LEN + 1; i++)
      pending_items.push_back(mk(lcs_pkg::MODE_FIRST, 8'h5A));
    for (int i = 0; i < MAX_LEN + 1; i++)
      pending_items.push_back(mk(lcs_pkg::MODE_SECOND, 8'h5A));
    pending_items.push_back(mk(lcs_pkg::MODE_RUN, 8'h00));
    // random: mostly short strings, few full ones, some noise
    n = 0;
    while (n < 400) begin
      int na, nb;
      case ($urandom_range(0, 9))
        0: begin na = MAX_LEN; nb = $urandom_range(MAX_LEN - 2, MAX_LEN + 2); end
        1: begin
          pending_items.push_back(mk(2'($urandom), 8'($urandom)));
          n++;
          continue;
        end
        default: begin na = $urandom_range(0, 8); nb = $urandom_range(0, 8); end
      endcase
      queue_pair(na, nb, ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(2, 4));
      n += na + nb + 1;
    end
    pending_items.push_back(mk(lcs_pkg::MODE_RUN, 8'h00));
  end

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_mode <= '0;
      in_symbol <= '0;
    end else if (!start || !busy) begin
      // previous transaction (if any) is accepted this edge
      if (start) begin
        apply_item('{mode: in_mode, symbol: in_symbol});
        sent_count++;
      end
      if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 7)) begin
        item_t it;
        it = pending_items.pop_front();
        start <= 1'b1;
        in_mode <= it.mode;
        in_symbol <= it.symbol;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      lcs_out_t e;
      got_count++;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected result char=%h", out_char));
      end else begin
        e = expected_chars.pop_front();
        if (out_char !== e.ch) report($sformatf("char %h exp %h", out_char, e.ch));
        if (out_char_valid !== e.ch_valid)
          report($sformatf("char_valid %b exp %b", out_char_valid, e.ch_valid));
        if (out_lcs_length !== e.length)
          report($sformatf("length %0d exp %0d", out_lcs_length, e.length));
        if (out_truncated !== e.trunc)
          report($sformatf("truncated %b exp %b", out_truncated, e.trunc));
        if (out_last !== e.last) report($sformatf("last %b exp %b", out_last, e.last));
      end
    end
  end

  // Watchdog and calm stretch
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    calm <= (sent_count > 150 && sent_count < 300);
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout with %0d results outstanding", expected_chars.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    errors = 0; sent_count = 0; run_count = 0; got_count = 0;
    len_a = 0; len_b = 0; dropped = 1'b0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    wait (pending_items.size() == 0);
    @(posedge clk);
    while (start) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d transactions, %0d runs, %0d result characters checked.",
             sent_count, run_count, got_count);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
